@@ rtl/kscr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kscr_pkg
// Types, constants and the usage code rom shared by the keypad scan blocks.
// ----------------------------------------------------------------------------
package kscr_pkg;

   localparam int KSCR_COLS       = 7;
   localparam int KSCR_ROWS       = 5;
   localparam int KSCR_CELLS      = KSCR_COLS * KSCR_ROWS;
   localparam int KSCR_IDX_W      = $clog2(KSCR_CELLS);
   localparam int KSCR_SLOT_DEPTH = 8;
   localparam int KSCR_SLOT_W     = $clog2(KSCR_SLOT_DEPTH);
   localparam int KSCR_CODE_W     = 8;
   localparam int KSCR_TIME_W     = 32;

   // defaults for the top level parameters
   localparam int KSCR_REPORT_SLOTS_DEF = 8;
   localparam int KSCR_HOLDOFF_MS_DEF   = 500;

   // mute combination: keypad minus (column 6, row 4) and keypad dot (column 5, row 0)
   localparam logic [KSCR_IDX_W-1:0] KSCR_MINUS_IDX = KSCR_IDX_W'(6 * KSCR_ROWS + 4);
   localparam logic [KSCR_IDX_W-1:0] KSCR_DOT_IDX   = KSCR_IDX_W'(5 * KSCR_ROWS + 0);

   typedef struct packed {
      logic [KSCR_ROWS-1:0]   rows_col0;
      logic [KSCR_ROWS-1:0]   rows_col1;
      logic [KSCR_ROWS-1:0]   rows_col2;
      logic [KSCR_ROWS-1:0]   rows_col3;
      logic [KSCR_ROWS-1:0]   rows_col4;
      logic [KSCR_ROWS-1:0]   rows_col5;
      logic [KSCR_ROWS-1:0]   rows_col6;
      logic [KSCR_TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [KSCR_SLOT_W-1:0] slot;
      logic [KSCR_CODE_W-1:0] keycode;
      logic                   report_changed;
      logic                   key_down_edge;
      logic                   mute_on;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [KSCR_IDX_W-1:0] limit;
   } walk_ctrl_type;

   typedef struct packed {
      logic busy;
      logic changed;
   } walk_stat_type;

   // hid usage code for each linear position, index = column * 5 + row
   function automatic logic [KSCR_CODE_W-1:0] usage_code(input logic [KSCR_IDX_W-1:0] idx);
      logic [KSCR_CODE_W-1:0] code;
      case (idx)
         6'd0:    code = 8'h50;
         6'd1:    code = 8'h00;
         6'd2:    code = 8'h4C;
         6'd3:    code = 8'h49;
         6'd4:    code = 8'h46;
         6'd5:    code = 8'h51;
         6'd6:    code = 8'h52;
         6'd7:    code = 8'h4D;
         6'd8:    code = 8'h4A;
         6'd9:    code = 8'h47;
         6'd10:   code = 8'h4F;
         6'd11:   code = 8'h00;
         6'd12:   code = 8'h4E;
         6'd13:   code = 8'h4B;
         6'd14:   code = 8'h48;
         6'd15:   code = 8'h62;
         6'd16:   code = 8'h5F;
         6'd17:   code = 8'h5C;
         6'd18:   code = 8'h59;
         6'd19:   code = 8'h53;
         6'd20:   code = 8'h00;
         6'd21:   code = 8'h60;
         6'd22:   code = 8'h5D;
         6'd23:   code = 8'h5A;
         6'd24:   code = 8'h54;
         6'd25:   code = 8'h63;
         6'd26:   code = 8'h61;
         6'd27:   code = 8'h5E;
         6'd28:   code = 8'h5B;
         6'd29:   code = 8'h55;
         6'd30:   code = 8'h00;
         6'd31:   code = 8'h58;
         6'd32:   code = 8'h00;
         6'd33:   code = 8'h57;
         6'd34:   code = 8'h56;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ rtl/kscr_walker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kscr_walker
// Walks the matrix one position a cycle against the stored snapshot and
// writes changed keycodes into the report slots.
// ----------------------------------------------------------------------------
module kscr_walker #(
   parameter int REPORT_SLOTS = kscr_pkg::KSCR_REPORT_SLOTS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  kscr_pkg::walk_ctrl_type               ctrl,
   input  wire [kscr_pkg::KSCR_CELLS-1:0]        pressed,
   input  wire [kscr_pkg::KSCR_SLOT_W-1:0]       rd_slot,
   output logic [kscr_pkg::KSCR_CODE_W-1:0]      rd_keycode,
   output logic [kscr_pkg::KSCR_CELLS-1:0]       prev_pressed,
   output kscr_pkg::walk_stat_type               stat
);
   import kscr_pkg::*;

   localparam int WPTR_W = $clog2(KSCR_SLOT_DEPTH + 1);

   logic                   active_ff;
   logic [KSCR_IDX_W-1:0]  idx_ff;
   logic [KSCR_IDX_W-1:0]  limit_ff;
   logic [WPTR_W-1:0]      wptr_ff;
   logic [WPTR_W-1:0]      wptr_in;
   logic                   changed_ff;
   logic [KSCR_CELLS-1:0]  prev_ff;
   logic [KSCR_CODE_W-1:0] slots_ff [KSCR_SLOT_DEPTH];
   logic                   diff;
   logic [KSCR_CODE_W-1:0] code;

   always_comb begin
      diff    = pressed[idx_ff] ^ prev_ff[idx_ff];
      code    = pressed[idx_ff] ? usage_code(idx_ff) : '0;
      wptr_in = wptr_ff + {{(WPTR_W-1){1'b0}}, diff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         idx_ff     <= '0;
         limit_ff   <= '0;
         wptr_ff    <= '0;
         changed_ff <= 1'b0;
         prev_ff    <= '0;
         for (int s = 0; s < KSCR_SLOT_DEPTH; s++) begin
            slots_ff[s] <= '0;
         end
      end else if (ctrl.start) begin
         active_ff  <= 1'b1;
         idx_ff     <= '0;
         limit_ff   <= ctrl.limit;
         wptr_ff    <= '0;
         changed_ff <= 1'b0;
      end else if (active_ff) begin
         // an unchanged position still clears the slot under the pointer
         slots_ff[wptr_ff[KSCR_SLOT_W-1:0]] <= diff ? code : '0;
         prev_ff[idx_ff] <= pressed[idx_ff];
         if (diff) begin
            changed_ff <= 1'b1;
         end
         wptr_ff <= wptr_in;
         idx_ff  <= idx_ff + 1'b1;
         if (idx_ff == limit_ff || wptr_in >= WPTR_W'(REPORT_SLOTS)) begin
            active_ff <= 1'b0;
         end
      end
   end

   assign rd_keycode   = slots_ff[rd_slot];
   assign prev_pressed = prev_ff;
   assign stat.busy    = active_ff;
   assign stat.changed = changed_ff;

endmodule
`default_nettype wire

@@ rtl/keypad_scan_change_report.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_scan_change_report
// Key matrix scan to keyboard report slots, with change detection and mute.
// ----------------------------------------------------------------------------
// One req_ item carries a full 7x5 scan and a millisecond time stamp. Each
// item produces REPORT_SLOTS rsp_ items, slot 0 first, with last set on the
// final one; report_changed, key_down_edge and mute_on repeat in each.
// Steps: ST_IDLE accepts the item, ST_LOAD resolves the edge, the mute
// toggle and the scan limit, then the walker compares one matrix position
// per cycle, up to scan limit + 1 positions (35 at most, fewer once
// REPORT_SLOTS changes are found), and the move to ST_EMIT hands the slots
// to the output. Results then stream one per cycle while rsp_ready is high;
// the block takes no new item until the last result is taken, and
// req_ready is low for the whole run.
// A stalled receiver simply holds the current result; nothing is lost.
// Reset (synchronous) clears the snapshot, the slots, the scan limit, the
// change flag, mute and the toggle time, and leaves the block ready.
// ----------------------------------------------------------------------------
module keypad_scan_change_report #(
   parameter int REPORT_SLOTS      = kscr_pkg::KSCR_REPORT_SLOTS_DEF,
   parameter int TOGGLE_HOLDOFF_MS = kscr_pkg::KSCR_HOLDOFF_MS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  kscr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output kscr_pkg::rsp_type rsp_data
);
   import kscr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   req_type                req_ff;
   logic                   mute_ff;
   logic [KSCR_TIME_W-1:0] last_toggle_ff;
   logic [KSCR_IDX_W-1:0]  scan_limit_ff;
   logic                   edge_ff;
   logic [KSCR_SLOT_W-1:0] emit_ff;

   logic [KSCR_CELLS-1:0]  raw;
   logic [KSCR_CELLS-1:0]  pressed;
   logic [KSCR_CELLS-1:0]  prev_pressed;
   logic [KSCR_IDX_W-1:0]  highest;
   logic [KSCR_IDX_W-1:0]  scan_limit_in;
   logic [KSCR_TIME_W-1:0] elapsed;
   logic                   toggle;
   logic                   edge_in;
   logic [KSCR_CODE_W-1:0] rd_keycode;
   walk_ctrl_type          walk_ctrl;
   walk_stat_type          walk_stat;

   // positions with a zero rom entry never count as pressed
   always_comb begin
      raw = {req_ff.rows_col6, req_ff.rows_col5, req_ff.rows_col4, req_ff.rows_col3,
             req_ff.rows_col2, req_ff.rows_col1, req_ff.rows_col0};
      for (int i = 0; i < KSCR_CELLS; i++) begin
         pressed[i] = raw[i] && (usage_code(KSCR_IDX_W'(i)) != '0);
      end
   end

   always_comb begin
      highest = '0;
      for (int i = 0; i < KSCR_CELLS; i++) begin
         if (pressed[i]) begin
            highest = KSCR_IDX_W'(i);
         end
      end
   end

   always_comb begin
      elapsed = req_ff.now_ms - last_toggle_ff;
      toggle  = pressed[KSCR_MINUS_IDX] && pressed[KSCR_DOT_IDX] &&
                (elapsed > KSCR_TIME_W'(TOGGLE_HOLDOFF_MS));
      edge_in = |(pressed & ~prev_pressed) && !toggle;
      scan_limit_in = (highest >= scan_limit_ff && !walk_stat.changed) ? highest
                                                                       : scan_limit_ff;
      walk_ctrl.start = (state_ff == ST_LOAD);
      walk_ctrl.limit = scan_limit_in;
   end

   kscr_walker #(
      .REPORT_SLOTS (REPORT_SLOTS)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (walk_ctrl),
      .pressed      (pressed),
      .rd_slot      (emit_ff),
      .rd_keycode   (rd_keycode),
      .prev_pressed (prev_pressed),
      .stat         (walk_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mute_ff        <= 1'b0;
         last_toggle_ff <= '0;
         scan_limit_ff  <= '0;
         edge_ff        <= 1'b0;
         emit_ff        <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               edge_ff       <= edge_in;
               scan_limit_ff <= scan_limit_in;
               if (toggle) begin
                  mute_ff        <= !mute_ff;
                  last_toggle_ff <= req_ff.now_ms;
               end
               state_ff <= ST_WALK;
            end
            ST_WALK: begin
               if (!walk_stat.busy) begin
                  emit_ff  <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  emit_ff <= emit_ff + 1'b1;
                  if (emit_ff == KSCR_SLOT_W'(REPORT_SLOTS - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      rsp_data.slot           = emit_ff;
      rsp_data.keycode        = rd_keycode;
      rsp_data.report_changed = walk_stat.changed;
      rsp_data.key_down_edge  = edge_ff;
      rsp_data.mute_on        = mute_ff;
      rsp_data.last           = (emit_ff == KSCR_SLOT_W'(REPORT_SLOTS - 1));
   end

endmodule
`default_nettype wire
